FILE: hw/rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants of the edge recombination crossover block.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int GENE_W = 4;
  localparam int RAND_W = 16;
  localparam int RC_W   = 5;
  localparam logic [RC_W-1:0] RC_RESET = 5'd16;

  typedef struct packed {
    logic              action;
    logic [GENE_W-1:0] gene_a;
    logic [GENE_W-1:0] gene_b;
    logic [RAND_W-1:0] rand_value;
  } in_t;

  typedef struct packed {
    logic [GENE_W-1:0] child_gene;
    logic              last;
  } out_t;

  typedef struct packed {
    logic load;
    logic emit_begin;
    logic mod_start_n;
    logic scan;
    logic classify;
    logic mod_start_size;
    logic take_idx;
    logic take_child;
    logic sel_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic new_child;
    logic scan_done;
    logic fallback;
    logic mod_done;
    logic sel_done;
  } sts_t;

endpackage

FILE: hw/rtl/erc_mod.sv
// ----------------------------------------------------------------------------
// erc_mod
// Restoring remainder unit: random word modulo a small count, one bit a cycle.
// ----------------------------------------------------------------------------
module erc_mod
  import erc_pkg::*;
#(
  parameter int NW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [NW-1:0]     divisor,
  output logic              done,
  output logic [NW-1:0]     rem
);

  localparam int BW = $clog2(RAND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic [RAND_W-1:0] q_r, q_nxt;
  logic [NW-1:0]     div_r, div_nxt;
  logic [NW-1:0]     rem_r, rem_nxt;
  logic [NW:0]       trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, q_r[RAND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = BW'(RAND_W - 1);
      q_nxt    = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = NW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = NW'(trial);
      end
      q_nxt = q_r << 1;
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/erc_ctrl.sv
// ----------------------------------------------------------------------------
// erc_ctrl
// Sequencer for load and emit transfers of the crossover block.
// ----------------------------------------------------------------------------
module erc_ctrl
  import erc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic action,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CLASS  = 3'd2;
  localparam logic [2:0] S_MODS   = 3'd3;
  localparam logic [2:0] S_MODN   = 3'd4;
  localparam logic [2:0] S_SELECT = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!action) begin
            cmd.load = 1'b1;
          end else begin
            cmd.emit_begin = 1'b1;
            if (sts.new_child) begin
              cmd.mod_start_n = 1'b1;
              state_nxt = S_MODN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        if (sts.fallback) begin
          state_nxt = S_SELECT;
        end else begin
          cmd.mod_start_size = 1'b1;
          state_nxt = S_MODS;
        end
      end
      S_MODS: begin
        if (sts.mod_done) begin
          cmd.take_idx = 1'b1;
          state_nxt = S_SELECT;
        end
      end
      S_MODN: begin
        if (sts.mod_done) begin
          cmd.take_child = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_SELECT: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mod_done |-> (state_r == S_MODS || state_r == S_MODN))
    else $error("remainder done outside a wait state");
  a_new_child_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && action && sts.new_child) |=> state_r == S_MODN)
    else $error("new child did not go to the first-element path");
`endif

endmodule

FILE: hw/rtl/erc_dp.sv
// ----------------------------------------------------------------------------
// erc_dp
// Parent stores, neighbour counting, candidate selection and result register.
// ----------------------------------------------------------------------------
module erc_dp
  import erc_pkg::*;
#(
  parameter int MAX_GENES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_t             in_data,
  input  logic            cfg_wr_en,
  input  logic [RC_W-1:0] cfg_wr_data,
  input  cmd_t            cmd,
  output sts_t            sts,
  output logic            out_valid,
  output out_t            out_data
);

  localparam int IW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int NW = $clog2(MAX_GENES + 1);
  localparam int SW = $clog2(MAX_GENES + 3);

  logic [GENE_W-1:0] mem_a [MAX_GENES];
  logic [GENE_W-1:0] mem_b [MAX_GENES];

  logic [RC_W-1:0]      rc_r;
  logic [NW-1:0]        n;
  logic [NW-1:0]        pos_r, pos_nxt, pos_w;
  logic [MAX_GENES-1:0] used_r, used_nxt;
  logic [GENE_W-1:0]    prev_r;
  logic [NW-1:0]        build_n_r;
  logic [NW-1:0]        k_r, k_cur;
  logic [RAND_W-1:0]    rnd_r;
  logic [SW-1:0]        s_r;
  logic                 rvld_r, rlast_r, issue;
  logic [1:0]           push_r;
  logic [IW-1:0]        rd_addr;
  logic [GENE_W-1:0]    ra_q, rb_q, w0a_r, w1a_r, w0b_r, w1b_r;
  logic [2:0]           cnt_r [MAX_GENES];
  logic [MAX_GENES-1:0] cand2, cand1, cand0, sel_vec_r;
  logic [NW-1:0]        size2, size1, idx_r, seen_r;
  logic [IW-1:0]        j_r, child_r;
  logic                 hit;
  logic                 mod_start, mod_done;
  logic [NW-1:0]        mod_div, mod_rem;
  logic [RAND_W-1:0]    mod_dvd;
  logic                 last_c;
  logic                 out_valid_r;
  out_t                 out_r;

  always_comb begin
    if (rc_r < RC_W'(2)) begin
      n = NW'(2);
    end else if (32'(rc_r) > MAX_GENES) begin
      n = NW'(MAX_GENES);
    end else begin
      n = NW'(rc_r);
    end
  end

  always_comb begin
    k_cur = '0;
    for (int j = 0; j < MAX_GENES; j++) begin
      if (j < 32'(n) && used_r[j]) k_cur = k_cur + 1'b1;
    end
  end

  assign sts.new_child = (k_cur == '0) || (k_cur >= n);

  always_comb begin
    pos_w = (pos_r >= n) ? '0 : pos_r;
    pos_nxt = pos_w + 1'b1;
    if (pos_nxt >= n) pos_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_a[pos_w[IW-1:0]] <= in_data.gene_a;
      mem_b[pos_w[IW-1:0]] <= in_data.gene_b;
    end
    ra_q <= mem_a[rd_addr];
    rb_q <= mem_b[rd_addr];
  end

  assign issue = cmd.scan && (s_r < SW'(build_n_r) + SW'(2));

  always_comb begin
    if (s_r == '0) begin
      rd_addr = IW'(build_n_r - 1'b1);
    end else if (s_r <= SW'(build_n_r)) begin
      rd_addr = IW'(s_r - 1'b1);
    end else begin
      rd_addr = '0;
    end
  end

  assign sts.scan_done = rvld_r && rlast_r;

  always_ff @(posedge clk) begin
    if (cmd.emit_begin) begin
      s_r     <= '0;
      rvld_r  <= 1'b0;
      rlast_r <= 1'b0;
      push_r  <= '0;
      for (int j = 0; j < MAX_GENES; j++) cnt_r[j] <= '0;
    end else begin
      if (issue) s_r <= s_r + 1'b1;
      rvld_r  <= issue;
      rlast_r <= issue && (s_r == SW'(build_n_r) + SW'(1));
      if (rvld_r) begin
        w0a_r <= w1a_r;
        w1a_r <= ra_q;
        w0b_r <= w1b_r;
        w1b_r <= rb_q;
        if (push_r != 2'd2) push_r <= push_r + 1'b1;
        if (push_r == 2'd2) begin
          for (int j = 0; j < MAX_GENES; j++) begin
            logic [3:0] sum;
            sum = {1'b0, cnt_r[j]};
            if (32'(prev_r) < 32'(build_n_r) && j < 32'(build_n_r)) begin
              if (w1a_r == prev_r && 32'(w0a_r) == j) sum = sum + 1'b1;
              if (w1a_r == prev_r && 32'(ra_q) == j)  sum = sum + 1'b1;
              if (w1b_r == prev_r && 32'(w0b_r) == j) sum = sum + 1'b1;
              if (w1b_r == prev_r && 32'(rb_q) == j)  sum = sum + 1'b1;
            end
            cnt_r[j] <= (sum > 4'd7) ? 3'd7 : sum[2:0];
          end
        end
      end
    end
  end

  always_comb begin
    size2 = '0;
    size1 = '0;
    for (int j = 0; j < MAX_GENES; j++) begin
      cand0[j] = (j < 32'(n)) && !used_r[j];
      cand2[j] = cand0[j] && (cnt_r[j] == 3'd2);
      cand1[j] = cand0[j] && (cnt_r[j] == 3'd1);
      if (cand2[j]) size2 = size2 + 1'b1;
      if (cand1[j]) size1 = size1 + 1'b1;
    end
  end

  assign sts.fallback = (size2 == '0) && (size1 == '0);

  assign mod_start = cmd.mod_start_n || cmd.mod_start_size;
  assign mod_dvd   = cmd.mod_start_n ? in_data.rand_value : rnd_r;
  assign mod_div   = cmd.mod_start_n ? n : ((size2 != '0) ? size2 : size1);

  erc_mod #(
    .NW(NW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign sts.mod_done = mod_done;

  assign hit = sel_vec_r[j_r] && (seen_r == idx_r);
  assign sts.sel_done = hit || (j_r == IW'(n - 1'b1));

  always_ff @(posedge clk) begin
    if (cmd.emit_begin) rnd_r <= in_data.rand_value;
    if (cmd.classify) begin
      sel_vec_r <= (size2 != '0) ? cand2 : ((size1 != '0) ? cand1 : cand0);
      idx_r     <= '0;
      j_r       <= '0;
      seen_r    <= '0;
    end
    if (cmd.take_idx) idx_r <= mod_rem;
    if (cmd.take_child) child_r <= IW'(mod_rem);
    if (cmd.sel_step) begin
      if (hit) begin
        child_r <= j_r;
      end else if (sts.sel_done) begin
        child_r <= '0;
      end
      if (sel_vec_r[j_r]) seen_r <= seen_r + 1'b1;
      j_r <= j_r + 1'b1;
    end
  end

  assign last_c = (NW'(k_r + 1'b1) == n);

  always_comb begin
    used_nxt = used_r;
    if (cmd.load) begin
      used_nxt = '0;
    end else if (cmd.emit_begin && sts.new_child) begin
      used_nxt = '0;
    end else if (cmd.commit) begin
      used_nxt = used_r | (MAX_GENES'(1) << child_r);
      if (last_c) used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= RC_RESET;
      pos_r       <= '0;
      used_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) rc_r <= cfg_wr_data;
      if (cmd.load) pos_r <= pos_nxt;
      used_r <= used_nxt;
      if (cmd.commit) prev_r <= GENE_W'(child_r);
      out_valid_r <= cmd.commit;
    end
    if (cmd.emit_begin) begin
      k_r <= sts.new_child ? '0 : k_cur;
      if (sts.new_child) build_n_r <= n;
    end
    if (cmd.commit) begin
      out_r.child_gene <= GENE_W'(child_r);
      out_r.last       <= last_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (used_r == '0))
    else $error("used mask not cleared after final element");
`endif

endmodule

FILE: hw/rtl/edge_recombination_crossover.sv
// ----------------------------------------------------------------------------
// edge_recombination_crossover
// Edge recombination crossover of two parent permutations, one child element
// per emit transfer.
// ----------------------------------------------------------------------------
// A load transfer (action 0) is taken while the block stays idle and gives
// no result. An emit transfer (action 1) holds busy until its result: the
// first element of a child waits on the 16-step remainder unit; a later
// element waits on the scan of both parent stores through their single read
// port, on the shared remainder unit when an unused neighbour is left, and
// on the candidate scan. The result appears on out_data with out_valid high
// for one cycle; the receiver cannot stall it, so it must take every strobe.
module edge_recombination_crossover
  import erc_pkg::*;
#(
  parameter int MAX_GENES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_t             in_data,
  output logic            out_valid,
  output out_t            out_data,
  input  logic            cfg_wr_en,
  input  logic [RC_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  erc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  erc_dp #(
    .MAX_GENES(MAX_GENES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
